[design/fgfw_pkg.sv]
// Shared types and constants of the glyph-to-frame writer.
// Depends on nothing; every other file of the block uses it.
package fgfw_pkg;

   // Item field widths fixed by the interface
   localparam int FUNC_W      = 2;
   localparam int FONT_ADDR_W = 12;
   localparam int BYTE_W      = 8;
   localparam int LINE_W      = 2;
   localparam int FB_ADDR_W   = 9;
   localparam int PEN_W       = 8;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DRAW    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NEW_MSG = 2'd2;

   // Text line codes
   localparam logic [LINE_W-1:0] LINE_UPPER = 2'd1;
   localparam logic [LINE_W-1:0] LINE_LOWER = 2'd2;

   // First code in the font (space)
   localparam logic [BYTE_W-1:0] FIRST_CODE = 8'd32;

   // Page numbers of the upper page of each text line
   localparam logic [1:0] PAGE_UPPER_LINE = 2'd0;
   localparam logic [1:0] PAGE_LOWER_LINE = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [FONT_ADDR_W-1:0] font_addr;
      logic [BYTE_W-1:0]      font_byte;
      logic [LINE_W-1:0]      text_line;
      logic [BYTE_W-1:0]      char_code;
   } req_type;

   typedef struct packed {
      logic [FB_ADDR_W-1:0] fb_addr;
      logic [BYTE_W-1:0]    fb_data;
      logic                 write_enable;
      logic                 last;
   } rsp_type;

   // Draw command handed to the sequencer
   typedef struct packed {
      logic [BYTE_W-1:0] code;
      logic              upper;
      logic [PEN_W-1:0]  pen;
   } start_cmd_type;

   // Pen write-back from the sequencer
   typedef struct packed {
      logic             valid;
      logic             upper;
      logic [PEN_W-1:0] pen;
   } pen_upd_type;

endpackage

[design/fgfw_font_ram.sv]
// Font memory: one write port, one read port with registered read data.
// Depends on fgfw_pkg for the byte width.
module fgfw_font_ram #(
   parameter int FONT_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(FONT_DEPTH)-1:0] wr_addr,
   input  logic [fgfw_pkg::BYTE_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(FONT_DEPTH)-1:0] rd_addr,
   output logic [fgfw_pkg::BYTE_W-1:0]   rd_data
);

   logic [fgfw_pkg::BYTE_W-1:0] mem [FONT_DEPTH];
   logic [fgfw_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fgfw_sequencer.sv]
// Glyph sequencer: computes the glyph base, checks the fit, then walks the glyph bytes
// through one shared address adder, one font read per cycle unless stalled. Depends on fgfw_pkg.
module fgfw_sequencer #(
   parameter int FONT_DEPTH    = 4096,
   parameter int GLYPH_COLUMNS = 12,
   parameter int GLYPH_BYTES   = 25,
   parameter int PAGE_WIDTH    = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  fgfw_pkg::start_cmd_type       start_cmd,
   input  logic                          out_free,
   input  logic [fgfw_pkg::BYTE_W-1:0]   rd_data,
   output logic                          idle,
   output logic                          rd_en,
   output logic [$clog2(FONT_DEPTH)-1:0] rd_addr,
   output logic                          beat_valid,
   output fgfw_pkg::rsp_type             beat,
   output fgfw_pkg::pen_upd_type         pen_upd
);

   localparam int AW       = $clog2(FONT_DEPTH);
   localparam int BASE_W   = $clog2(223 * GLYPH_BYTES + 1);
   localparam int SUM_W    = $clog2(224 * GLYPH_BYTES + 2 * GLYPH_COLUMNS + 1);
   localparam int OFF_W    = $clog2(2 * GLYPH_COLUMNS + 2);
   localparam int COL_W    = $clog2(256 + GLYPH_COLUMNS);
   localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(2 * GLYPH_COLUMNS);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_BASE  = 4'b0010,
      S_CHECK = 4'b0100,
      S_RUN   = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   logic [fgfw_pkg::BYTE_W-1:0] code_ff, code_in;
   logic                        upper_ff, upper_in;
   logic [fgfw_pkg::PEN_W-1:0]  pen_ff, pen_in;
   logic [BASE_W-1:0]           base_ff, base_in;
   logic [OFF_W-1:0]            fetch_ff, fetch_in;
   logic                        pend_ff, pend_in;
   logic [OFF_W-1:0]            pend_off_ff, pend_off_in;
   logic                        pend_oob_ff, pend_oob_in;
   logic [fgfw_pkg::BYTE_W-1:0] width_ff, width_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic                        hi_ff, hi_in;

   logic [fgfw_pkg::BYTE_W-1:0] code_off;
   logic [SUM_W-1:0]            opnd;
   logic [SUM_W-1:0]            sum;
   logic                        oob;
   logic                        more;
   logic                        pend_is_width;
   logic [fgfw_pkg::BYTE_W-1:0] data;
   logic                        emit;
   logic                        consume;
   logic                        issue;
   logic                        beat_last;
   logic                        clipped;
   logic [1:0]                  page;

   // Shared adder: glyph end in the check step, byte address while running
   assign code_off = code_ff - fgfw_pkg::FIRST_CODE;
   assign opnd     = (state_ff == S_CHECK) ? SUM_W'(GLYPH_BYTES) : SUM_W'(fetch_ff);
   assign sum      = SUM_W'(base_ff) + opnd;
   assign oob      = 32'(sum) >= FONT_DEPTH;

   assign more          = fetch_ff <= LAST_OFF;
   assign pend_is_width = pend_off_ff == '0;
   assign data          = pend_oob_ff ? '0 : rd_data;
   assign emit          = pend_ff && !pend_is_width && out_free;
   assign consume       = pend_ff && (pend_is_width || out_free);
   assign issue         = (state_ff == S_RUN) && more && (!pend_ff || consume);
   assign beat_last     = pend_off_ff == LAST_OFF;

   assign rd_en   = issue && !oob;
   assign rd_addr = AW'(sum);

   assign clipped = 32'(col_ff) >= PAGE_WIDTH;
   assign page    = (upper_ff ? fgfw_pkg::PAGE_UPPER_LINE : fgfw_pkg::PAGE_LOWER_LINE)
                    + {1'b0, hi_ff};

   always_comb begin
      beat.fb_addr      = clipped ? '0
                          : fgfw_pkg::FB_ADDR_W'(32'(page) * PAGE_WIDTH + 32'(col_ff));
      beat.fb_data      = clipped ? '0 : data;
      beat.write_enable = !clipped;
      beat.last         = beat_last;
   end

   assign beat_valid = emit;
   assign idle       = state_ff == S_IDLE;

   assign pen_upd.valid = emit && beat_last;
   assign pen_upd.upper = upper_ff;
   assign pen_upd.pen   = pen_ff + width_ff;

   always_comb begin
      state_in    = state_ff;
      code_in     = code_ff;
      upper_in    = upper_ff;
      pen_in      = pen_ff;
      base_in     = base_ff;
      fetch_in    = fetch_ff;
      pend_in     = pend_ff;
      pend_off_in = pend_off_ff;
      pend_oob_in = pend_oob_ff;
      width_in    = width_ff;
      col_in      = col_ff;
      hi_in       = hi_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               code_in  = start_cmd.code;
               upper_in = start_cmd.upper;
               pen_in   = start_cmd.pen;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            base_in  = BASE_W'(32'(code_off) * GLYPH_BYTES);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // Drop glyphs that do not fit in the font memory
            if (32'(sum) > FONT_DEPTH) begin
               state_in = S_IDLE;
            end else begin
               fetch_in = '0;
               pend_in  = 1'b0;
               col_in   = COL_W'(pen_ff);
               hi_in    = 1'b0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (consume) begin
               pend_in = 1'b0;
               if (pend_is_width) begin
                  width_in = data;
               end
            end
            if (emit) begin
               hi_in = !hi_ff;
               if (hi_ff) begin
                  col_in = col_ff + COL_W'(1);
               end
               if (beat_last) begin
                  state_in = S_IDLE;
               end
            end
            if (issue) begin
               pend_in     = 1'b1;
               pend_off_in = fetch_ff;
               pend_oob_in = oob;
               fetch_in    = fetch_ff + OFF_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      upper_ff    <= upper_in;
      pen_ff      <= pen_in;
      base_ff     <= base_in;
      fetch_ff    <= fetch_in;
      pend_off_ff <= pend_off_in;
      pend_oob_ff <= pend_oob_in;
      width_ff    <= width_in;
      col_ff      <= col_in;
      hi_ff       <= hi_in;
   end

endmodule

[design/font_glyph_to_frame_writer_top.sv]
// Top level of the glyph-to-frame writer: request decode, pens, output register.
// Depends on fgfw_pkg, fgfw_font_ram and fgfw_sequencer.
//
//   channel   | ports                         | one beat carries
//   ----------+-------------------------------+-------------------------------------
//   request   | req_valid, req_ready, req_data | font load, draw or new-message item
//   response  | rsp_valid, rsp_ready, rsp_data | one frame-buffer write of a glyph
//
// Load and new-message items are done as they are accepted. A draw runs in steps:
// the base multiply, the fit check on the shared adder, then one font read per
// cycle through the single read port, the width byte first. req_ready is low
// while a draw is in flight. A stalled response holds the sequencer, which stops
// issuing reads until the output register frees. Reset clears both pens, the
// sequencer and the output register; the font memory is not cleared.
module font_glyph_to_frame_writer_top #(
   parameter int FONT_DEPTH    = 4096,
   parameter int GLYPH_COLUMNS = 12,
   parameter int GLYPH_BYTES   = 25,
   parameter int PAGE_WIDTH    = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fgfw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fgfw_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(FONT_DEPTH);

   logic                        req_accept;
   logic                        is_load;
   logic                        is_draw;
   logic                        is_new_msg;
   logic                        line_ok;
   logic                        start;
   fgfw_pkg::start_cmd_type     start_cmd;
   logic                        ram_wr_en;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [fgfw_pkg::BYTE_W-1:0] ram_rd_data;
   logic                        seq_idle;
   logic                        out_free;
   logic                        beat_valid;
   fgfw_pkg::rsp_type           beat;
   fgfw_pkg::pen_upd_type       pen_upd;

   logic [fgfw_pkg::PEN_W-1:0]  pen_upper_ff, pen_upper_in;
   logic [fgfw_pkg::PEN_W-1:0]  pen_lower_ff, pen_lower_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   fgfw_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // Accept items only while no glyph is being walked
   assign req_ready  = seq_idle;
   assign req_accept = req_valid && req_ready;

   assign is_load    = req_data.func == fgfw_pkg::FUNC_LOAD;
   assign is_draw    = req_data.func == fgfw_pkg::FUNC_DRAW;
   assign is_new_msg = req_data.func == fgfw_pkg::FUNC_NEW_MSG;
   assign line_ok    = (req_data.text_line == fgfw_pkg::LINE_UPPER)
                    || (req_data.text_line == fgfw_pkg::LINE_LOWER);

   // Drop draws on a bad line or with a control character right here
   assign start = req_accept && is_draw && line_ok
                  && (req_data.char_code >= fgfw_pkg::FIRST_CODE);

   assign start_cmd.code  = req_data.char_code;
   assign start_cmd.upper = req_data.text_line == fgfw_pkg::LINE_UPPER;
   assign start_cmd.pen   = (req_data.text_line == fgfw_pkg::LINE_UPPER)
                            ? pen_upper_ff : pen_lower_ff;

   // Ignore loads past the end of the font memory
   assign ram_wr_en = req_accept && is_load && (32'(req_data.font_addr) < FONT_DEPTH);

   fgfw_font_ram #(
      .FONT_DEPTH (FONT_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_data.font_addr)),
      .wr_data (req_data.font_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fgfw_sequencer #(
      .FONT_DEPTH    (FONT_DEPTH),
      .GLYPH_COLUMNS (GLYPH_COLUMNS),
      .GLYPH_BYTES   (GLYPH_BYTES),
      .PAGE_WIDTH    (PAGE_WIDTH)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_cmd  (start_cmd),
      .out_free   (out_free),
      .rd_data    (ram_rd_data),
      .idle       (seq_idle),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .beat_valid (beat_valid),
      .beat       (beat),
      .pen_upd    (pen_upd)
   );

   // Pens: clear on new message, advance after the last beat of a glyph
   always_comb begin
      pen_upper_in = pen_upper_ff;
      pen_lower_in = pen_lower_ff;
      if (req_accept && is_new_msg) begin
         pen_upper_in = '0;
         pen_lower_in = '0;
      end else if (pen_upd.valid) begin
         if (pen_upd.upper) begin
            pen_upper_in = pen_upd.pen;
         end else begin
            pen_lower_in = pen_upd.pen;
         end
      end
   end

   // Output register: take a new beat when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (beat_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = beat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_upper_ff <= '0;
         pen_lower_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_upper_ff <= pen_upper_in;
         pen_lower_ff <= pen_lower_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A drawable character closes the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start |=> !req_ready)
      else $error("request side still open after a draw started");

   // A clipped write carries neither address nor data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.write_enable) |->
         (rsp_data.fb_addr == '0) && (rsp_data.fb_data == '0))
      else $error("clipped write with nonzero address or data");

   // The pen advances exactly with the last beat of a glyph
   assert property (@(posedge clock) disable iff (reset)
      pen_upd.valid == (beat_valid && beat.last))
      else $error("pen update out of step with the last beat");

   // Beats only leave the sequencer into a free output register
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !beat_valid)
      else $error("beat pushed into a full output register");

endmodule

[tb/testbench.sv]
// Self-checking bench for font_glyph_to_frame_writer_top: loads glyphs, draws text,
// checks writes. Depends on fgfw_pkg and the block's RTL; keeps its own font image and pens.
module testbench;

   // Block geometry at its default parameters
   localparam int FONT_DEPTH    = 4096;
   localparam int GLYPH_COLUMNS = 12;
   localparam int GLYPH_BYTES   = 25;
   localparam int PAGE_WIDTH    = 128;

   // Codes the package leaves unnamed
   localparam logic [fgfw_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [fgfw_pkg::LINE_W-1:0] LINE_NONE   = 2'd0;
   localparam logic [fgfw_pkg::LINE_W-1:0] LINE_SPARE  = 2'd3;

   localparam int IDLE_PERCENT  = 15;
   // Leave margin past the last write
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 10;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   fgfw_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   fgfw_pkg::rsp_type rsp_data;

   // Predictor state: font image and the two pens
   logic [fgfw_pkg::BYTE_W-1:0] font_image [FONT_DEPTH];
   logic [fgfw_pkg::PEN_W-1:0]  upper_pen;
   logic [fgfw_pkg::PEN_W-1:0]  lower_pen;

   // Codes whose whole glyph has been loaded; only these may be drawn
   logic [fgfw_pkg::BYTE_W-1:0] drawable_codes [$];
   // Frame-buffer writes still owed by the block, oldest first
   fgfw_pkg::rsp_type           frame_writes [$];

   int mismatches = 0;
   bit steady;   // set: neither side idles

   font_glyph_to_frame_writer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Apply one accepted beat to the predictor: update the font or pens and queue
   // the writes a draw produces.
   task automatic expand_item(input fgfw_pkg::req_type it);
      int                         base;
      int                         col;
      logic [fgfw_pkg::PEN_W-1:0] pen;
      logic [1:0]                 first_page;
      bit                         upper;
      fgfw_pkg::rsp_type          w;
      case (it.func)
         fgfw_pkg::FUNC_LOAD: begin
            font_image[it.font_addr] = it.font_byte;
         end
         fgfw_pkg::FUNC_NEW_MSG: begin
            upper_pen = '0;
            lower_pen = '0;
         end
         fgfw_pkg::FUNC_DRAW: begin
            // Drop draws on a bad line, control characters and glyphs past the font
            if ((it.text_line == fgfw_pkg::LINE_UPPER || it.text_line == fgfw_pkg::LINE_LOWER) &&
                it.char_code >= fgfw_pkg::FIRST_CODE) begin
               base = (int'(it.char_code) - int'(fgfw_pkg::FIRST_CODE)) * GLYPH_BYTES;
               if (base + GLYPH_BYTES <= FONT_DEPTH) begin
                  upper      = (it.text_line == fgfw_pkg::LINE_UPPER);
                  pen        = upper ? upper_pen : lower_pen;
                  first_page = upper ? fgfw_pkg::PAGE_UPPER_LINE : fgfw_pkg::PAGE_LOWER_LINE;
                  for (int i = 0; i < GLYPH_COLUMNS; i++) begin
                     col = int'(pen) + i;
                     for (int k = 0; k < 2; k++) begin
                        w = '0;
                        // Columns past the right edge come out clipped with zero fields
                        if (col < PAGE_WIDTH) begin
                           w.fb_addr      = fgfw_pkg::FB_ADDR_W'(
                                               (int'(first_page) + k) * PAGE_WIDTH + col);
                           w.fb_data      = font_image[base + 1 + 2 * i + k];
                           w.write_enable = 1'b1;
                        end
                        w.last = (i == GLYPH_COLUMNS - 1) && (k == 1);
                        frame_writes.push_back(w);
                     end
                  end
                  // Advance the pen by the glyph width, wrapping at 8 bits
                  pen = pen + font_image[base];
                  if (upper)
                     upper_pen = pen;
                  else
                     lower_pen = pen;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Send one beat: maybe idle first, then hold valid until the block takes it.
   // Valid stays high afterwards so a following beat goes out back to back.
   task automatic issue_item(input fgfw_pkg::req_type item);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      expand_item(item);
   endtask

   // Beat builders; fields the function ignores carry random junk
   function automatic fgfw_pkg::req_type load_beat(
      input logic [fgfw_pkg::FONT_ADDR_W-1:0] addr,
      input logic [fgfw_pkg::BYTE_W-1:0]      data);
      fgfw_pkg::req_type r;
      r           = fgfw_pkg::req_type'($urandom);
      r.func      = fgfw_pkg::FUNC_LOAD;
      r.font_addr = addr;
      r.font_byte = data;
      return r;
   endfunction

   function automatic fgfw_pkg::req_type draw_beat(
      input logic [fgfw_pkg::LINE_W-1:0] line,
      input logic [fgfw_pkg::BYTE_W-1:0] code);
      fgfw_pkg::req_type r;
      r           = fgfw_pkg::req_type'($urandom);
      r.func      = fgfw_pkg::FUNC_DRAW;
      r.text_line = line;
      r.char_code = code;
      return r;
   endfunction

   function automatic fgfw_pkg::req_type cmd_beat(input logic [fgfw_pkg::FUNC_W-1:0] func);
      fgfw_pkg::req_type r;
      r      = fgfw_pkg::req_type'($urandom);
      r.func = func;
      return r;
   endfunction

   function automatic logic [fgfw_pkg::LINE_W-1:0] any_line();
      return $urandom_range(1) ? fgfw_pkg::LINE_UPPER : fgfw_pkg::LINE_LOWER;
   endfunction

   function automatic logic [fgfw_pkg::BYTE_W-1:0] any_drawable();
      return drawable_codes[$urandom_range(drawable_codes.size() - 1)];
   endfunction

   // Load a full glyph: width byte, then column pairs with some all-set and
   // all-clear bytes mixed into random ones.
   task automatic load_glyph(input logic [fgfw_pkg::BYTE_W-1:0] code,
                             input logic [fgfw_pkg::BYTE_W-1:0] width);
      int                          base;
      logic [fgfw_pkg::BYTE_W-1:0] data;
      base = (int'(code) - int'(fgfw_pkg::FIRST_CODE)) * GLYPH_BYTES;
      issue_item(load_beat(fgfw_pkg::FONT_ADDR_W'(base), width));
      for (int j = 1; j < GLYPH_BYTES; j++) begin
         case (j % 6)
            1:       data = 8'hFF;
            2:       data = 8'h00;
            default: data = fgfw_pkg::BYTE_W'($urandom);
         endcase
         issue_item(load_beat(fgfw_pkg::FONT_ADDR_W'(base + j), data));
      end
      drawable_codes.push_back(code);
   endtask

   // Font set-up: space with zero width, a plain glyph, a wide one, the last
   // glyph that fits with the largest width, a couple of others, and the top
   // byte of memory.
   task automatic test_font_load();
      logic [fgfw_pkg::BYTE_W-1:0] extra_codes [2] = '{8'd48, 8'd150};
      load_glyph(fgfw_pkg::FIRST_CODE, 8'd0);
      load_glyph(8'd65, 8'd12);
      load_glyph(8'd127, 8'd100);
      load_glyph(8'd194, 8'd255);
      foreach (extra_codes[n])
         load_glyph(extra_codes[n], fgfw_pkg::BYTE_W'($urandom_range(1, 40)));
      issue_item(load_beat(12'hFFF, 8'hA5));
   endtask

   // Draws on both lines, pen wrap, dropped items, and a glyph that runs off
   // the right edge part way and then wholly.
   task automatic test_directed_draws();
      issue_item(cmd_beat(fgfw_pkg::FUNC_NEW_MSG));
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, fgfw_pkg::FIRST_CODE));
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, 8'd65));
      issue_item(draw_beat(fgfw_pkg::LINE_LOWER, 8'd65));
      issue_item(draw_beat(fgfw_pkg::LINE_LOWER, 8'd194));   // width 255 wraps the pen
      issue_item(draw_beat(fgfw_pkg::LINE_LOWER, 8'd65));
      issue_item(draw_beat(LINE_NONE, 8'd65));
      issue_item(draw_beat(LINE_SPARE, 8'd65));
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, 8'd31));
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, 8'd0));
      issue_item(draw_beat(fgfw_pkg::LINE_LOWER, 8'd195));   // first code past the font
      issue_item(draw_beat(fgfw_pkg::LINE_LOWER, 8'd255));
      issue_item(cmd_beat(FUNC_UNUSED));
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, 8'd127));   // pen 12 -> 112
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, 8'd65));    // columns 112..123
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, 8'd65));    // columns 124..135, partly clipped
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, 8'd65));    // wholly clipped
      issue_item(cmd_beat(fgfw_pkg::FUNC_NEW_MSG));
      issue_item(draw_beat(fgfw_pkg::LINE_UPPER, 8'd65));
      issue_item(draw_beat(fgfw_pkg::LINE_LOWER, 8'd65));
   endtask

   // Mostly draws of loaded glyphs, with font rewrites, new messages and
   // dropped items mixed in.
   task automatic test_random_stream(input int count);
      int                          pick;
      int                          base;
      logic [fgfw_pkg::BYTE_W-1:0] code;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            issue_item(draw_beat(any_line(), any_drawable()));
         end else if (pick < 65) begin
            if ($urandom_range(1)) begin
               // Rewrite a byte of a loaded glyph, width byte included
               code = any_drawable();
               base = (int'(code) - int'(fgfw_pkg::FIRST_CODE)) * GLYPH_BYTES;
               issue_item(load_beat(
                  fgfw_pkg::FONT_ADDR_W'(base + $urandom_range(GLYPH_BYTES - 1)),
                  fgfw_pkg::BYTE_W'($urandom)));
            end else begin
               issue_item(load_beat(fgfw_pkg::FONT_ADDR_W'($urandom),
                                    fgfw_pkg::BYTE_W'($urandom)));
            end
         end else if (pick < 73) begin
            issue_item(cmd_beat(fgfw_pkg::FUNC_NEW_MSG));
         end else if (pick < 78) begin
            issue_item(cmd_beat(FUNC_UNUSED));
         end else if (pick < 84) begin
            issue_item(draw_beat($urandom_range(1) ? LINE_NONE : LINE_SPARE, any_drawable()));
         end else if (pick < 92) begin
            issue_item(draw_beat(any_line(), fgfw_pkg::BYTE_W'($urandom_range(31))));
         end else begin
            issue_item(draw_beat(any_line(), fgfw_pkg::BYTE_W'($urandom_range(195, 255))));
         end
      end
   endtask

   task automatic report_write(input string what, input fgfw_pkg::rsp_type got,
                               input fgfw_pkg::rsp_type want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display({"%s: got addr %0d data %02h we %0b last %0b,",
                   " expected addr %0d data %02h we %0b last %0b"},
                  what, got.fb_addr, got.fb_data, got.write_enable, got.last,
                  want.fb_addr, want.fb_data, want.write_enable, want.last);
   endtask

   // Check every write beat against the oldest expected write; stall the
   // response side at random except during the steady stretch.
   always @(posedge clock) begin : write_check
      fgfw_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_writes.size() == 0) begin
            report_write("unexpected write", rsp_data, '0);
         end else begin
            want = frame_writes.pop_front();
            if (rsp_data.fb_addr !== want.fb_addr || rsp_data.fb_data !== want.fb_data ||
                rsp_data.write_enable !== want.write_enable || rsp_data.last !== want.last)
               report_write("write mismatch", rsp_data, want);
         end
      end
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      steady     = 1'b0;
      upper_pen  = '0;
      lower_pen  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_font_load();
      test_directed_draws();
      steady = 1'b1;
      test_random_stream(30);
      steady = 1'b0;
      test_random_stream(70);

      // Drop valid, drain the owed writes, then let the block settle
      req_valid <= 1'b0;
      while (frame_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && frame_writes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog: stop a hung run
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
